FILE: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, types and register codes for the set-associative cache
// lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // Cache geometry
    localparam int WAYS         = 4;
    localparam int MAX_SET_BITS = 6;
    localparam int BLOCK_WIDTH  = 30;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = WAY_W;

    // Fixed field widths
    localparam int ADDR_W     = 30;
    localparam int SET_OUT_W  = 6;
    localparam int WAY_OUT_W  = 2;
    localparam int EVBLK_W    = 30;
    localparam int CNT_W      = 32;
    localparam int OFFSET_W   = 4;
    localparam int SETBITS_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETBITS = 2'd2;

    // Register reset values
    localparam logic                 RST_POLICY  = 1'b0;
    localparam logic [OFFSET_W-1:0]  RST_OFFSET  = 4'd2;
    localparam logic [SETBITS_W-1:0] RST_SETBITS = 3'd6;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Request queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Classified request passed from front to back
    typedef struct packed {
        logic [BLOCK_WIDTH-1:0] blk;
        logic [SET_W-1:0]       set;
    } req_t;

    // One set row in the tag RAM: tags, LRU ranks and FIFO pointer
    typedef struct packed {
        logic [WAYS-1:0][BLOCK_WIDTH-1:0] tags;
        logic [WAYS-1:0][RANK_W-1:0]      rank;
        logic [WAY_W-1:0]                 fptr;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Result handed to the output port
    typedef struct packed {
        logic                 hit;
        logic [SET_OUT_W-1:0] set_index;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 evicted;
        logic [EVBLK_W-1:0]   evicted_block;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
    } res_t;

    // Back-end state machine
    typedef enum logic {
        BK_IDLE,
        BK_LOOKUP
    } bk_state_t;

endpackage

FILE: rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sacl_front.sv
// ----------------------------------------------------------------------------
// sacl_front
// Holds the configuration registers and classifies each incoming address
// into its block number and set.
// ----------------------------------------------------------------------------
module sacl_front
    import sacl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ADDR_W-1:0]     word_address,
    output req_t                  req,
    output logic                  policy
);

    logic                 policy_reg,  policy_next;
    logic [OFFSET_W-1:0]  offset_reg,  offset_next;
    logic [SETBITS_W-1:0] setbits_reg, setbits_next;

    logic [ADDR_W-1:0]      shifted;
    logic [BLOCK_WIDTH-1:0] blk;
    logic [SETBITS_W-1:0]   sb;
    logic [SET_W-1:0]       set_mask;

    // Register write decode
    always_comb
    begin
        policy_next  = policy_reg;
        offset_next  = offset_reg;
        setbits_next = setbits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY:  policy_next  = cfg_data[0];
                CFG_OFFSET:  offset_next  = cfg_data[OFFSET_W-1:0];
                CFG_SETBITS: setbits_next = cfg_data[SETBITS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= RST_POLICY;
            offset_reg  <= RST_OFFSET;
            setbits_reg <= RST_SETBITS;
        end
        else
        begin
            policy_reg  <= policy_next;
            offset_reg  <= offset_next;
            setbits_reg <= setbits_next;
        end
    end

    // Block number and set selection
    always_comb
    begin
        shifted  = word_address >> offset_reg;
        blk      = BLOCK_WIDTH'(shifted);
        sb       = (setbits_reg > SETBITS_W'(MAX_SET_BITS)) ?
                   SETBITS_W'(MAX_SET_BITS) : setbits_reg;
        set_mask = ~({SET_W{1'b1}} << sb);
        req.blk  = blk;
        req.set  = SET_W'(blk) & set_mask;
    end

    assign policy = policy_reg;

endmodule

FILE: rtl/sacl_queue.sv
// ----------------------------------------------------------------------------
// sacl_queue
// Short request FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module sacl_queue
    import sacl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_data,
    input  logic pop,
    output req_t head,
    output logic full,
    output logic empty
);

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    // Pointer and occupancy update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rptr_reg];
    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

FILE: rtl/sacl_back.sv
// ----------------------------------------------------------------------------
// sacl_back
// Executes one lookup at a time: reads the set row, compares tags, picks a
// victim, updates tags, ranks, FIFO pointer and valid bits, and registers
// the result.
// ----------------------------------------------------------------------------
module sacl_back
    import sacl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic policy,
    input  req_t q_head,
    input  logic q_empty,
    output logic q_pop,
    output logic out_valid,
    input  logic out_stall,
    output res_t res
);

    bk_state_t state_reg, state_next;

    logic [BLOCK_WIDTH-1:0] blk_reg, blk_next;
    logic [SET_W-1:0]       set_reg, set_next;
    logic [WAYS-1:0]        vld_reg [NUM_SETS];
    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   res_reg, res_next;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic             commit;

    row_t                   row;
    row_t                   row_new;
    logic [WAYS-1:0]        vld;
    logic                   hit_w;
    logic [WAY_W-1:0]       way;
    logic [WAY_W-1:0]       hit_way;
    logic [WAY_W-1:0]       free_way;
    logic                   has_free;
    logic [WAY_W-1:0]       lru_way;
    logic [RANK_W-1:0]      best;
    logic                   do_touch;
    logic [RANK_W:0]        limit;
    logic                   ev_w;
    logic [BLOCK_WIDTH-1:0] ev_blk;

    // Tag, rank and pointer store, one row per set
    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_head.set),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (!q_empty) state_next = BK_LOOKUP;
            BK_LOOKUP: if (!out_valid_reg || !out_stall) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop  = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            BK_IDLE:   q_pop  = !q_empty;
            BK_LOOKUP: commit = !out_valid_reg || !out_stall;
            default:   ;
        endcase
    end

    assign ram_re = q_pop;

    // Lookup, victim choice and row update
    always_comb
    begin
        vld = vld_reg[set_reg];
        row = row_t'(ram_rdata);
        // Untouched set: pointer and ranks are cleared before use
        if (vld == '0)
        begin
            row.rank = '0;
            row.fptr = '0;
        end

        // Lowest matching way
        hit_w   = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vld[w] && (row.tags[w] == blk_reg))
            begin
                hit_w   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // Lowest free way
        has_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!vld[w])
            begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        // Oldest way, lowest index on a tie
        best    = '0;
        lru_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row.rank[w] > best)
            begin
                best    = row.rank[w];
                lru_way = WAY_W'(w);
            end
        end

        // Way selection
        if (hit_w)
        begin
            way = hit_way;
        end
        else if (policy == POLICY_FIFO)
        begin
            way = row.fptr;
        end
        else if (has_free)
        begin
            way = free_way;
        end
        else
        begin
            way = lru_way;
        end

        row_new  = row;
        do_touch = (policy == POLICY_LRU);

        // FIFO pointer advances on a FIFO miss
        if (!hit_w && (policy == POLICY_FIFO))
        begin
            row_new.fptr = (row.fptr == WAY_W'(WAYS - 1)) ? '0 : row.fptr + 1'b1;
        end

        // Recency update: ways younger than the touched way age by one
        limit = vld[way] ? {1'b0, row.rank[way]} : (RANK_W + 1)'(WAYS);
        if (do_touch)
        begin
            for (int v = 0; v < WAYS; v++)
            begin
                if ((WAY_W'(v) != way) && vld[v] && ({1'b0, row.rank[v]} < limit) &&
                    (row.rank[v] < RANK_W'(WAYS - 1)))
                begin
                    row_new.rank[v] = row.rank[v] + 1'b1;
                end
            end
            row_new.rank[way] = '0;
        end

        // Eviction and fill
        ev_w   = !hit_w && vld[way];
        ev_blk = ev_w ? row.tags[way] : '0;
        if (!hit_w)
        begin
            row_new.tags[way] = blk_reg;
        end
        ram_wdata = ROW_W'(row_new);
    end

    // Counters and result
    always_comb
    begin
        blk_next       = blk_reg;
        set_next       = set_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (q_pop)
        begin
            blk_next = q_head.blk;
            set_next = q_head.set;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            if (hit_w && (hit_cnt_reg != '1))
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
            if (!hit_w && (miss_cnt_reg != '1))
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
            out_valid_next         = 1'b1;
            res_next.hit           = hit_w;
            res_next.set_index     = SET_OUT_W'(set_reg);
            res_next.way_used      = WAY_OUT_W'(way);
            res_next.evicted       = ev_w;
            res_next.evicted_block = EVBLK_W'(ev_blk);
            res_next.hit_total     = hit_cnt_next;
            res_next.miss_total    = miss_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        set_reg <= set_next;
        res_reg <= res_next;
    end

    // Valid bits, one per set and way
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                vld_reg[s] <= '0;
            end
        end
        else if (commit && !hit_w)
        begin
            vld_reg[set_reg][way] <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/set_assoc_cache_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup
// Set-associative cache hit/miss tracker with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Each accepted request (a word address) gives exactly one result. The front
// splits the address into block number and set and pushes it into a
// two-entry queue; the back end takes one request at a time: its idle state
// pops the request and reads the set's row (tags, ranks, FIFO pointer) from
// the tag RAM, and its lookup state compares, updates and writes the row back.
// Because of this read-modify-write on the single tag RAM port pair, a new
// request is taken only after the last one is written back, and the lookup
// state waits while a previous result is held by out_stall.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed
// and requests are taken right after reset. Configuration must be written
// only while no request is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup
    import sacl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ADDR_W-1:0]     word_address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [SET_OUT_W-1:0]  set_index,
    output logic [WAY_OUT_W-1:0]  way_used,
    output logic                  evicted,
    output logic [EVBLK_W-1:0]    evicted_block,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total
);

    req_t req;
    req_t q_head;
    logic policy;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    res_t res;

    // Front: configuration and classification
    sacl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .word_address (word_address),
        .req          (req),
        .policy       (policy)
    );

    assign q_push   = in_valid && !q_full;
    assign in_stall = q_full;

    // Request queue
    sacl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (req),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: lookup and update
    sacl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .policy    (policy),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign hit           = res.hit;
    assign set_index     = res.set_index;
    assign way_used      = res.way_used;
    assign evicted       = res.evicted;
    assign evicted_block = res.evicted_block;
    assign hit_total     = res.hit_total;
    assign miss_total    = res.miss_total;

`ifndef ASSERT_OFF
    // The back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // A pop is never followed by another pop in the next cycle
    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("back end popped on consecutive cycles");

    // Only a miss may report an eviction
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> !hit)
        else $error("eviction reported on a hit");
`endif

endmodule

FILE: tb/sv/set_assoc_cache_lookup_test.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_test
// Self-checking bench for the set-associative cache lookup block. A shadow
// copy of the tag store, valid bits, FIFO pointers and LRU ranks predicts the
// result of every accepted request. Named tests cover the reset settings,
// LRU ordering, field extremes, random register settings with FIFO/LRU
// switching, a long output hold-off and a final full-rate stretch.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_test;

    import sacl_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int POOL_DEPTH     = 16;

    // Index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Clock, reset and block inputs, all known from time zero
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic [ADDR_W-1:0]     word_address = '0;
    logic                  out_stall    = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  hit;
    logic [SET_OUT_W-1:0]  set_index;
    logic [WAY_OUT_W-1:0]  way_used;
    logic                  evicted;
    logic [EVBLK_W-1:0]    evicted_block;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;

    // Shadow register settings
    logic                 cfg_policy  = RST_POLICY;
    logic [OFFSET_W-1:0]  cfg_offset  = RST_OFFSET;
    logic [SETBITS_W-1:0] cfg_setbits = RST_SETBITS;

    // Shadow cache state
    logic [BLOCK_WIDTH-1:0] shadow_tags  [NUM_SETS][WAYS];
    bit                     shadow_valid [NUM_SETS][WAYS];
    int                     shadow_rank  [NUM_SETS][WAYS];
    int                     shadow_fptr  [NUM_SETS];
    logic [CNT_W-1:0]       shadow_hits   = '0;
    logic [CNT_W-1:0]       shadow_misses = '0;

    res_t              pending_results[$];
    logic [ADDR_W-1:0] recent_addrs[$];
    int                mismatches = 0;

    // Traffic shaping knobs
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_left  = 0;

    set_assoc_cache_lookup DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .word_address  (word_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .set_index     (set_index),
        .way_used      (way_used),
        .evicted       (evicted),
        .evicted_block (evicted_block),
        .hit_total     (hit_total),
        .miss_total    (miss_total)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Make way w most recent; valid ways newer than it age by one
    function automatic void promote_way(int s, int w);
        int limit;
        limit = shadow_valid[s][w] ? shadow_rank[s][w] : WAYS;
        for (int v = 0; v < WAYS; v++)
        begin
            if (v != w && shadow_valid[s][v] && shadow_rank[s][v] < limit &&
                shadow_rank[s][v] < WAYS - 1)
                shadow_rank[s][v]++;
        end
        shadow_rank[s][w] = 0;
    endfunction

    // Look one address up in the shadow cache and update it
    function automatic res_t lookup_address(logic [ADDR_W-1:0] addr);
        logic [BLOCK_WIDTH-1:0] blk;
        int   sb;
        int   s;
        int   way;
        int   best;
        bit   found;
        res_t r;
        blk   = addr >> cfg_offset;
        sb    = (cfg_setbits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_setbits;
        s     = int'(blk[SET_W-1:0]) & ((1 << sb) - 1);
        way   = 0;
        found = 1'b0;
        r     = '0;

        // lowest matching way wins
        for (int w = 0; w < WAYS && !found; w++)
        begin
            if (shadow_valid[s][w] && shadow_tags[s][w] == blk)
            begin
                found = 1'b1;
                way   = w;
            end
        end

        if (found)
        begin
            if (cfg_policy == POLICY_LRU)
                promote_way(s, way);
            if (shadow_hits != '1)
                shadow_hits++;
        end
        else
        begin
            if (cfg_policy == POLICY_FIFO)
            begin
                way = shadow_fptr[s] % WAYS;
                shadow_fptr[s] = (way + 1) % WAYS;
            end
            else
            begin
                // free way first, else oldest valid way
                bit got_free;
                got_free = 1'b0;
                for (int w = 0; w < WAYS && !got_free; w++)
                begin
                    if (!shadow_valid[s][w])
                    begin
                        way      = w;
                        got_free = 1'b1;
                    end
                end
                if (!got_free)
                begin
                    best = 0;
                    way  = 0;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (shadow_rank[s][w] > best)
                        begin
                            best = shadow_rank[s][w];
                            way  = w;
                        end
                    end
                end
                promote_way(s, way);
            end
            if (shadow_valid[s][way])
            begin
                r.evicted       = 1'b1;
                r.evicted_block = shadow_tags[s][way];
            end
            shadow_tags[s][way]  = blk;
            shadow_valid[s][way] = 1'b1;
            if (shadow_misses != '1)
                shadow_misses++;
        end

        r.hit        = found;
        r.set_index  = SET_OUT_W'(s);
        r.way_used   = WAY_OUT_W'(way);
        r.hit_total  = shadow_hits;
        r.miss_total = shadow_misses;
        return r;
    endfunction

    function automatic int cfg_setbits_used();
        return (cfg_setbits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_setbits;
    endfunction

    // Address of a given tag and set under the current settings
    function automatic logic [ADDR_W-1:0] addr_for(int tag, int set_no);
        logic [63:0] blk;
        blk = (64'(tag) << cfg_setbits_used()) | 64'(set_no);
        return ADDR_W'(blk << cfg_offset);
    endfunction

    // Random address: mostly reuse and set conflicts, some fully random
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [63:0] blk;
        logic [63:0] low_mask;
        logic [63:0] a;
        int          sb;
        int          kind;
        sb       = cfg_setbits_used();
        low_mask = (64'd1 << cfg_offset) - 1;
        kind     = $urandom_range(0, 99);
        if (kind < 45 && recent_addrs.size() > 0)
        begin
            a = 64'(recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]);
            a = (a & ~low_mask) | ({$urandom, $urandom} & low_mask);
        end
        else if (kind < 85)
        begin
            blk = (64'($urandom_range(0, 7)) << sb) |
                  64'($urandom_range(0, 3) & ((1 << sb) - 1));
            a   = (blk << cfg_offset) | ({$urandom, $urandom} & low_mask);
        end
        else
            a = {$urandom, $urandom};
        return a[ADDR_W-1:0];
    endfunction

    // One register write; the block must be idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_POLICY:  cfg_policy  = data[0];
            CFG_OFFSET:  cfg_offset  = data;
            CFG_SETBITS: cfg_setbits = data[SETBITS_W-1:0];
            default:     ;
        endcase
    endtask

    // Write all three registers, unused data bits random
    task automatic apply_settings(logic pol, int off, int sb);
        logic [CFG_DATA_W-1:0] pad;
        pad = CFG_DATA_W'($urandom);
        write_reg(CFG_POLICY, {pad[CFG_DATA_W-1:1], pol});
        write_reg(CFG_OFFSET, CFG_DATA_W'(off));
        write_reg(CFG_SETBITS, {pad[CFG_DATA_W-1], SETBITS_W'(sb)});
    endtask

    // Offer one request and log its prediction once accepted
    task automatic send_request(logic [ADDR_W-1:0] addr);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        word_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), lookup_address(addr));
        recent_addrs.insert(recent_addrs.size(), addr);
        if (recent_addrs.size() > POOL_DEPTH)
            void'(recent_addrs.pop_front());
    endtask

    // Stop offering, wait for all results and let the pipe settle
    task automatic finish_phase();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reset settings: FIFO fill, wrap and eviction in set 0, top address
    task automatic test_reset_config();
        write_reg(CFG_SPARE, '1);
        send_request(addr_for(0, 0));
        send_request('1);
        send_request('1);
        send_request(ADDR_W'(3));
        for (int t = 1; t <= 4; t++)
            send_request(addr_for(t, 0));
        send_request(addr_for(0, 0));
        send_request(addr_for(2, 0));
        finish_phase();
    endtask

    // LRU: fill, touch, evict oldest; then a full set with all ranks equal
    task automatic test_lru_order();
        apply_settings(POLICY_LRU, 2, 6);
        for (int t = 0; t < 4; t++)
            send_request(addr_for(t, 5));
        send_request(addr_for(0, 5));
        send_request(addr_for(2, 5));
        send_request(addr_for(4, 5));
        send_request(addr_for(5, 5));
        send_request(addr_for(4, 5));
        send_request(addr_for(9, 0));
        finish_phase();
    endtask

    // No offset and one set; then the largest offset and set bits past the cap
    task automatic test_field_extremes();
        apply_settings(POLICY_FIFO, 0, 0);
        send_request('0);
        send_request('1);
        send_request(ADDR_W'(30'h2AAAAAAA));
        send_request(ADDR_W'(30'h15555555));
        send_request('0);
        finish_phase();
        apply_settings(POLICY_LRU, 15, 7);
        send_request('1);
        send_request(ADDR_W'(30'h3FFF8000));
        send_request('0);
        finish_phase();
    endtask

    // Several register settings, policy switching without reset
    task automatic test_random_settings();
        logic phase_pol[7] = '{POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO,
                               POLICY_LRU, POLICY_FIFO, POLICY_LRU};
        int   phase_off[7] = '{2, 0, 8, 15, 4, 1, 0};
        int   phase_sb[7]  = '{6, 0, 2, 7, 7, 3, 0};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 7)
                apply_settings(phase_pol[ph], phase_off[ph], phase_sb[ph]);
            else
                apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                               $urandom_range(0, 7));
            tx_idle_en = (ph % 3 != 2);
            rx_idle_en = (ph % 4 != 3);
            repeat (80) send_request(pick_address());
            finish_phase();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Long output hold-off while requests keep coming
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_left  = 150;
        repeat (20) send_request(pick_address());
        finish_phase();
        tx_idle_en = 1'b1;
    endtask

    // Closing stretch with no idling on either side
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        apply_settings(POLICY_LRU, 2, 3);
        repeat (60) send_request(pick_address());
        finish_phase();
    endtask

    // Receiver: long hold when asked, otherwise random stall bursts
    initial
    begin
        int burst_left;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        res_t seen;
        bit   bad;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.hit           = hit;
            seen.set_index     = set_index;
            seen.way_used      = way_used;
            seen.evicted       = evicted;
            seen.evicted_block = evicted_block;
            seen.hit_total     = hit_total;
            seen.miss_total    = miss_total;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result with no request outstanding, set %0d way %0d",
                             $time, seen.set_index, seen.way_used);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                bad  = (seen.hit !== want.hit) ||
                       (seen.set_index !== want.set_index) ||
                       (seen.way_used !== want.way_used) ||
                       (seen.evicted !== want.evicted) ||
                       (seen.evicted_block !== want.evicted_block) ||
                       (seen.hit_total !== want.hit_total) ||
                       (seen.miss_total !== want.miss_total);
                if (bad)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: lookup mismatch", $time);
                        $display("  want hit=%0d set=%0d way=%0d ev=%0d evblk=%h hits=%0d misses=%0d",
                                 want.hit, want.set_index, want.way_used, want.evicted,
                                 want.evicted_block, want.hit_total, want.miss_total);
                        $display("  got  hit=%0d set=%0d way=%0d ev=%0d evblk=%h hits=%0d misses=%0d",
                                 seen.hit, seen.set_index, seen.way_used, seen.evicted,
                                 seen.evicted_block, seen.hit_total, seen.miss_total);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Hang guard
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("set_assoc_cache_lookup verification failed");
        $finish;
    end

    // Test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_lru_order();
        test_field_extremes();
        test_random_settings();
        test_backpressure();
        test_full_rate();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("set_assoc_cache_lookup verification clean");
        else
            $display("set_assoc_cache_lookup verification failed");
        $finish;
    end

endmodule

FILE: set_assoc_cache_lookup.f
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_front.sv
rtl/sacl_queue.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lookup.sv
tb/sv/set_assoc_cache_lookup_test.sv
